// ===== src/basis_matrix_from_direction_defines.svh =====
`ifndef BASIS_MATRIX_FROM_DIRECTION_DEFINES_SVH
`define BASIS_MATRIX_FROM_DIRECTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BMFD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bmfd_pkg.sv =====
`default_nettype none

package bmfd_pkg;

	localparam int unsigned FRAC_BITS_DEF = 12;
	localparam int unsigned DIM = 3;
	localparam int unsigned NCOMP = 9;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned MAG_W = 32;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned ROOT_W = 32;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [MAG_W:0] wide_t;

	typedef struct packed {
		val_t [DIM-1:0] dir;
		val_t [DIM-1:0] scl;
		val_t [DIM-1:0] pos;
	} in_t;

	// component order: right xyz, up xyz, forward xyz
	typedef struct packed {
		wide_t [NCOMP-1:0] v;
		val_t [DIM-1:0] scl;
		val_t [DIM-1:0] pos;
	} s2_t;

	typedef struct packed {
		logic [NCOMP-1:0][MAG_W-1:0] mag;
		logic [NCOMP-1:0] neg;
		logic [NCOMP-1:0][SUM_W-1:0] sq;
		val_t [DIM-1:0] scl;
		val_t [DIM-1:0] pos;
	} s3_t;

	typedef struct packed {
		logic [NCOMP-1:0][MAG_W-1:0] mag;
		logic [NCOMP-1:0] neg;
		val_t [DIM-1:0] scl;
		val_t [DIM-1:0] pos;
	} sq_side_t;

	typedef struct packed {
		logic [DIM-1:0][SUM_W-1:0] sum;
		sq_side_t side;
	} s4_t;

	typedef struct packed {
		logic [NCOMP-1:0] neg;
		logic [DIM-1:0] zero;
		val_t [DIM-1:0] scl;
		val_t [DIM-1:0] pos;
	} dv_side_t;

	typedef struct packed {
		val_t [NCOMP-1:0] res;
		val_t [DIM-1:0] trans;
	} out_t;

endpackage

`default_nettype wire

// ===== src/bmfd_pipe_reg.sv =====
`default_nettype none

module bmfd_pipe_reg #(
	parameter int unsigned W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	logic         vld_q;
	logic [W-1:0] data_q;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/bmfd_isqrt.sv =====
`default_nettype none
`include "basis_matrix_from_direction_defines.svh"

// one root bit per stage, three lanes in lockstep
module bmfd_isqrt #(
	parameter int unsigned SW = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          in_valid,
	output logic                                               in_ready,
	input  wire logic [bmfd_pkg::DIM-1:0][bmfd_pkg::SUM_W-1:0] in_rad,
	input  wire logic [SW-1:0]                                 in_side,
	output logic                                               out_valid,
	input  wire logic                                          out_ready,
	output logic [bmfd_pkg::DIM-1:0][bmfd_pkg::ROOT_W-1:0]     out_root,
	output logic [SW-1:0]                                      out_side
);

	localparam int unsigned NS = bmfd_pkg::ROOT_W;
	localparam int unsigned RW = bmfd_pkg::SUM_W;
	localparam int unsigned REM_W = NS + 3;
	localparam int unsigned ND = bmfd_pkg::DIM;

	logic [NS-1:0] vld_s;
	logic [NS:0]   en;
	logic [ND-1:0][RW-1:0]    rad_s  [NS];
	logic [ND-1:0][REM_W-1:0] rem_s  [NS];
	logic [ND-1:0][NS-1:0]    root_s [NS];
	logic [SW-1:0]            side_s [NS];

	assign en[NS]    = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_side  = side_s[NS-1];

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic                     pv;
		logic [ND-1:0][RW-1:0]    prad, nrad;
		logic [ND-1:0][REM_W-1:0] prem, nrem;
		logic [ND-1:0][NS-1:0]    proot, nroot;
		logic [SW-1:0]            pside;

		assign en[k] = !vld_s[k] || en[k+1];

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prad  = in_rad;
			assign prem  = '0;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign prad  = rad_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		always_comb begin
			logic [REM_W-1:0] r2;
			logic [REM_W-1:0] t;
			for (int l = 0; l < ND; l++) begin
				r2 = {prem[l][REM_W-3:0], prad[l][RW-1 -: 2]};
				t  = REM_W'({proot[l], 2'b01});
				nrad[l] = prad[l] << 2;
				if (r2 >= t) begin
					nrem[l]  = r2 - t;
					nroot[l] = {proot[l][NS-2:0], 1'b1};
				end else begin
					nrem[l]  = r2;
					nroot[l] = {proot[l][NS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && pv) begin
				rad_s[k]  <= nrad;
				rem_s[k]  <= nrem;
				root_s[k] <= nroot;
				side_s[k] <= pside;
			end
		end
	end

	for (genvar l = 0; l < ND; l++) begin : g_chk
		`BMFD_ASSERT(a_rem_bound, out_valid, rem_s[NS-1][l] <= REM_W'({out_root[l], 1'b0}), "sqrt remainder exceeds twice the root")
	end

endmodule

`default_nettype wire

// ===== src/bmfd_div.sv =====
`default_nettype none
`include "basis_matrix_from_direction_defines.svh"

// restoring divider, one quotient bit per stage, nine lanes in lockstep
module bmfd_div #(
	parameter int unsigned QW = 13,
	parameter int unsigned SW = 8
) (
	input  wire logic                                                           clk,
	input  wire logic                                                           arst_n,
	input  wire logic                                                           in_valid,
	output logic                                                                in_ready,
	input  wire logic [bmfd_pkg::NCOMP-1:0][bmfd_pkg::ROOT_W+QW-1:0]           in_num,
	input  wire logic [bmfd_pkg::NCOMP-1:0][bmfd_pkg::ROOT_W-1:0]              in_den,
	input  wire logic [SW-1:0]                                                  in_side,
	output logic                                                                out_valid,
	input  wire logic                                                           out_ready,
	output logic [bmfd_pkg::NCOMP-1:0][QW-1:0]                                  out_quo,
	output logic [SW-1:0]                                                       out_side
);

	localparam int unsigned DW = bmfd_pkg::ROOT_W;
	localparam int unsigned NW = DW + QW;
	localparam int unsigned NL = bmfd_pkg::NCOMP;

	logic [QW-1:0] vld_s;
	logic [QW:0]   en;
	logic [NL-1:0][NW-1:0] num_s [QW];
	logic [NL-1:0][DW-1:0] den_s [QW];
	logic [NL-1:0][QW-1:0] quo_s [QW];
	logic [SW-1:0]         side_s [QW];

	assign en[QW]    = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int unsigned SH = QW - 1 - k;
		logic                  pv;
		logic [NL-1:0][NW-1:0] pnum, nnum;
		logic [NL-1:0][DW-1:0] pden;
		logic [NL-1:0][QW-1:0] pquo, nquo;
		logic [SW-1:0]         pside;

		assign en[k] = !vld_s[k] || en[k+1];

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pnum  = in_num;
			assign pden  = in_den;
			assign pquo  = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign pnum  = num_s[k-1];
			assign pden  = den_s[k-1];
			assign pquo  = quo_s[k-1];
			assign pside = side_s[k-1];
		end

		always_comb begin
			logic [NW-1:0] dsh;
			for (int l = 0; l < NL; l++) begin
				dsh = NW'(pden[l]) << SH;
				if (pnum[l] >= dsh) begin
					nnum[l] = pnum[l] - dsh;
					nquo[l] = {pquo[l][QW-2:0], 1'b1};
				end else begin
					nnum[l] = pnum[l];
					nquo[l] = {pquo[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && pv) begin
				num_s[k]  <= nnum;
				den_s[k]  <= pden;
				quo_s[k]  <= nquo;
				side_s[k] <= pside;
			end
		end
	end

	for (genvar l = 0; l < NL; l++) begin : g_chk
		`BMFD_ASSERT(a_rem_lt_den, out_valid && (den_s[QW-1][l] != '0), num_s[QW-1][l] < NW'(den_s[QW-1][l]), "division remainder not below divisor")
	end

endmodule

`default_nettype wire

// ===== src/basis_matrix_from_direction.sv =====
`default_nettype none
`include "basis_matrix_from_direction_defines.svh"

// Builds a scaled look-rotation frame from a direction: right = (0,1,0) x dir,
// up = dir x right, each normalized (zero length gives zero) and scaled by
// scale x/y/z, with the position passed through as translation. Signed fixed
// point with FRAC_BITS fraction bits, saturating. Fully pipelined: one request
// per cycle while the output does not stall; 4 setup stages, 32 square-root
// stages, FRAC_BITS + 1 divider stages, 2 scaling stages. Empty stages
// collapse under output stall.
module basis_matrix_from_direction #(
	parameter int unsigned FRAC_BITS = bmfd_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] dir_x,
	input  wire logic [15:0] dir_y,
	input  wire logic [15:0] dir_z,
	input  wire logic [15:0] scale_x,
	input  wire logic [15:0] scale_y,
	input  wire logic [15:0] scale_z,
	input  wire logic [15:0] pos_x,
	input  wire logic [15:0] pos_y,
	input  wire logic [15:0] pos_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      right_x,
	output logic [15:0]      right_y,
	output logic [15:0]      right_z,
	output logic [15:0]      up_x,
	output logic [15:0]      up_y,
	output logic [15:0]      up_z,
	output logic [15:0]      fwd_x,
	output logic [15:0]      fwd_y,
	output logic [15:0]      fwd_z,
	output logic [15:0]      trans_x,
	output logic [15:0]      trans_y,
	output logic [15:0]      trans_z
);

	localparam int unsigned QW = FRAC_BITS + 1;
	localparam int unsigned NW = bmfd_pkg::ROOT_W + QW;
	localparam int unsigned NV = FRAC_BITS + 2;
	localparam int unsigned PW = NV + bmfd_pkg::VAL_W;
	localparam int unsigned NC = bmfd_pkg::NCOMP;
	localparam int unsigned ND = bmfd_pkg::DIM;
	localparam int unsigned VW = bmfd_pkg::VAL_W;
	localparam int unsigned W5 = NC * PW + ND * VW;

	bmfd_pkg::in_t      d0, d1;
	bmfd_pkg::s2_t      c1, d2;
	bmfd_pkg::s3_t      c2, d3;
	bmfd_pkg::s4_t      c3, d4;
	bmfd_pkg::sq_side_t sqo;
	bmfd_pkg::dv_side_t c4, dvo;
	bmfd_pkg::out_t     c6, d6;

	logic v1, r1, v2, r2, v3, r3, v4, r4, vq, rq, vd, rd, v5, r5;
	logic [ND-1:0][bmfd_pkg::ROOT_W-1:0] root;
	logic [NC-1:0][NW-1:0]               num;
	logic [NC-1:0][bmfd_pkg::ROOT_W-1:0] den;
	logic [NC-1:0][QW-1:0]               quo;
	logic [NC-1:0][PW-1:0]               c5_p, d5_p;
	logic [ND-1:0][VW-1:0]               d5_pos;
	logic [W5-1:0]                       c5, d5;

	assign d0.dir = {dir_z, dir_y, dir_x};
	assign d0.scl = {scale_z, scale_y, scale_x};
	assign d0.pos = {pos_z, pos_y, pos_x};

	bmfd_pipe_reg #(.W($bits(bmfd_pkg::in_t))) u_s1 (
		.clk, .arst_n,
		.in_valid(in_valid), .in_ready(in_ready), .in_data(d0),
		.out_valid(v1), .out_ready(r1), .out_data(d1)
	);

	always_comb begin
		logic signed [VW-1:0] dx, dy, dz;
		logic signed [31:0]   pxy, pxx, pzz, pyz;
		dx  = $signed(d1.dir[0]);
		dy  = $signed(d1.dir[1]);
		dz  = $signed(d1.dir[2]);
		pxy = dx * dy;
		pxx = dx * dx;
		pzz = dz * dz;
		pyz = dy * dz;
		c1.v[0] = 33'(dz);
		c1.v[1] = '0;
		c1.v[2] = -33'(dx);
		c1.v[3] = -33'(pxy);
		c1.v[4] = 33'(pxx) + 33'(pzz);
		c1.v[5] = -33'(pyz);
		c1.v[6] = 33'(dx);
		c1.v[7] = 33'(dy);
		c1.v[8] = 33'(dz);
		c1.scl  = d1.scl;
		c1.pos  = d1.pos;
	end

	bmfd_pipe_reg #(.W($bits(bmfd_pkg::s2_t))) u_s2 (
		.clk, .arst_n,
		.in_valid(v1), .in_ready(r1), .in_data(c1),
		.out_valid(v2), .out_ready(r2), .out_data(d2)
	);

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			c2.neg[c] = d2.v[c][bmfd_pkg::MAG_W];
			c2.mag[c] = c2.neg[c] ? bmfd_pkg::MAG_W'(-d2.v[c]) : bmfd_pkg::MAG_W'(d2.v[c]);
			c2.sq[c]  = bmfd_pkg::SUM_W'(c2.mag[c]) * bmfd_pkg::SUM_W'(c2.mag[c]);
		end
		c2.scl = d2.scl;
		c2.pos = d2.pos;
	end

	bmfd_pipe_reg #(.W($bits(bmfd_pkg::s3_t))) u_s3 (
		.clk, .arst_n,
		.in_valid(v2), .in_ready(r2), .in_data(c2),
		.out_valid(v3), .out_ready(r3), .out_data(d3)
	);

	always_comb begin
		for (int k = 0; k < ND; k++) begin
			c3.sum[k] = d3.sq[3*k] + d3.sq[3*k+1] + d3.sq[3*k+2];
		end
		c3.side.mag = d3.mag;
		c3.side.neg = d3.neg;
		c3.side.scl = d3.scl;
		c3.side.pos = d3.pos;
	end

	bmfd_pipe_reg #(.W($bits(bmfd_pkg::s4_t))) u_s4 (
		.clk, .arst_n,
		.in_valid(v3), .in_ready(r3), .in_data(c3),
		.out_valid(v4), .out_ready(r4), .out_data(d4)
	);

	bmfd_isqrt #(.SW($bits(bmfd_pkg::sq_side_t))) u_sqrt (
		.clk, .arst_n,
		.in_valid(v4), .in_ready(r4), .in_rad(d4.sum), .in_side(d4.side),
		.out_valid(vq), .out_ready(rq), .out_root(root), .out_side(sqo)
	);

	// numerator carries the half-divisor rounding term
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			num[c] = (NW'(sqo.mag[c]) << FRAC_BITS) + NW'(root[c/3] >> 1);
			den[c] = root[c/3];
		end
		for (int k = 0; k < ND; k++) begin
			c4.zero[k] = (root[k] == '0);
		end
		c4.neg = sqo.neg;
		c4.scl = sqo.scl;
		c4.pos = sqo.pos;
	end

	bmfd_div #(.QW(QW), .SW($bits(bmfd_pkg::dv_side_t))) u_div (
		.clk, .arst_n,
		.in_valid(vq), .in_ready(rq), .in_num(num), .in_den(den), .in_side(c4),
		.out_valid(vd), .out_ready(rd), .out_quo(quo), .out_side(dvo)
	);

	always_comb begin
		logic [QW-1:0]        qc;
		logic signed [NV-1:0] n;
		for (int c = 0; c < NC; c++) begin
			qc = (quo[c] > QW'(1 << FRAC_BITS)) ? QW'(1 << FRAC_BITS) : quo[c];
			if (dvo.zero[c/3]) begin
				n = '0;
			end else if (dvo.neg[c]) begin
				n = -$signed(NV'(qc));
			end else begin
				n = $signed(NV'(qc));
			end
			c5_p[c] = PW'($signed(PW'(n)) * $signed(PW'($signed(dvo.scl[c/3]))));
		end
	end

	assign c5 = {c5_p, dvo.pos};

	bmfd_pipe_reg #(.W(W5)) u_s5 (
		.clk, .arst_n,
		.in_valid(vd), .in_ready(rd), .in_data(c5),
		.out_valid(v5), .out_ready(r5), .out_data(d5)
	);

	assign {d5_p, d5_pos} = d5;

	// round half away from zero, then saturate
	always_comb begin
		logic          pn;
		logic [PW-1:0] pm;
		logic [PW-1:0] r;
		for (int c = 0; c < NC; c++) begin
			pn = d5_p[c][PW-1];
			pm = pn ? -d5_p[c] : d5_p[c];
			r  = (pm + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (!pn) begin
				c6.res[c] = (r > PW'(32767)) ? 16'sh7fff : $signed(r[VW-1:0]);
			end else begin
				c6.res[c] = (r > PW'(32768)) ? 16'sh8000 : $signed(-r[VW-1:0]);
			end
		end
		c6.trans = d5_pos;
	end

	bmfd_pipe_reg #(.W($bits(bmfd_pkg::out_t))) u_s6 (
		.clk, .arst_n,
		.in_valid(v5), .in_ready(r5), .in_data(c6),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(d6)
	);

	assign right_x = d6.res[0];
	assign right_y = d6.res[1];
	assign right_z = d6.res[2];
	assign up_x    = d6.res[3];
	assign up_y    = d6.res[4];
	assign up_z    = d6.res[5];
	assign fwd_x   = d6.res[6];
	assign fwd_y   = d6.res[7];
	assign fwd_z   = d6.res[8];
	assign trans_x = d6.trans[0];
	assign trans_y = d6.trans[1];
	assign trans_z = d6.trans[2];

	`BMFD_ASSERT(a_quo_le_one, vd && !dvo.zero[1], quo[4] <= QW'(1 << FRAC_BITS), "normalized up y exceeds one")
	`BMFD_ASSERT(a_fwd_quo_le_one, vd && !dvo.zero[2], quo[6] <= QW'(1 << FRAC_BITS) && quo[7] <= QW'(1 << FRAC_BITS), "normalized forward exceeds one")
	`BMFD_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(d6), "stalled result changed")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 12;
	localparam int N_RAND = 1850;
	localparam int LATENCY = FB + 39;
	localparam longint LIMIT = 400000;

	typedef logic signed [15:0] q_t;

	typedef struct packed {
		q_t dx, dy, dz, sx, sy, sz, px, py, pz;
	} req_t;

	typedef struct packed {
		q_t rx, ry, rz, ux, uy, uz, fx, fy, fz, tx, ty, tz;
	} frame_t;

	typedef struct {
		req_t r;
		bit has_exp;
		frame_t e;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [15:0] dir_x, dir_y, dir_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z;
	logic [15:0] right_x, right_y, right_z, up_x, up_y, up_z;
	logic [15:0] fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z;

	frame_t frames_due[$];
	int errors;
	longint cycles;
	bit stim_done;

	basis_matrix_from_direction uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint isqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic q_t sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return q_t'(v);
	endfunction

	function automatic void unit_scaled(input longint v[3], input longint s, output q_t o[3]);
		longint unsigned sq, len, q, m, r;
		longint n, p, one;
		one = longint'(1) << FB;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m = v[i] < 0 ? -v[i] : v[i];
			sq += m * m;
		end
		len = isqrt(sq);
		for (int i = 0; i < 3; i++) begin
			n = 0;
			if (len != 0) begin
				m = v[i] < 0 ? -v[i] : v[i];
				q = (m * one + len / 2) / len;
				if (q > one) q = one;
				n = v[i] < 0 ? -longint'(q) : longint'(q);
			end
			p = n * s;
			r = ((p < 0 ? -p : p) + (longint'(1) << (FB - 1))) >> FB;
			o[i] = sat16(p < 0 ? -longint'(r) : longint'(r));
		end
	endfunction

	function automatic frame_t look_frame(req_t r);
		frame_t f;
		longint dx, dy, dz;
		longint fv[3], rv[3], uv[3];
		q_t o[3];
		dx = r.dx; dy = r.dy; dz = r.dz;
		fv = '{dx, dy, dz};
		rv = '{dz, 0, -dx};
		uv = '{-(dx * dy), dx * dx + dz * dz, -(dy * dz)};
		unit_scaled(rv, r.sx, o); f.rx = o[0]; f.ry = o[1]; f.rz = o[2];
		unit_scaled(uv, r.sy, o); f.ux = o[0]; f.uy = o[1]; f.uz = o[2];
		unit_scaled(fv, r.sz, o); f.fx = o[0]; f.fy = o[1]; f.fz = o[2];
		f.tx = r.px; f.ty = r.py; f.tz = r.pz;
		return f;
	endfunction

	task automatic report(string what, q_t got, q_t want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic req_t rand_req();
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 5))
			0: begin r.dx = '0; r.dz = '0; end
			1: begin r.dx = '0; r.dy = '0; r.dz = '0; end
			2: begin
				r.dx = q_t'($urandom_range(0, 8192) - 4096);
				r.dy = q_t'($urandom_range(0, 8192) - 4096);
				r.dz = q_t'($urandom_range(0, 8192) - 4096);
				r.sx = q_t'($urandom_range(0, 16384) - 8192);
				r.sy = q_t'($urandom_range(0, 16384) - 8192);
				r.sz = q_t'($urandom_range(0, 16384) - 8192);
			end
			3: begin
				r.dx = q_t'($urandom_range(0, 6) - 3);
				r.dy = q_t'($urandom_range(0, 6) - 3);
				r.dz = q_t'($urandom_range(0, 6) - 3);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send(req_t r);
		{dir_x, dir_y, dir_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z} = r;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		frames_due.push_back(look_frame(r));
		@(negedge clk);
	endtask

	// 0x1000 is 1.0
	row_t directed[$];
	initial begin
		frame_t z;
		req_t r;
		int burst;
		z = '0;
		directed.push_back('{req_t'({16'sd0, 16'sd0, 16'sd0, 16'sh1000, 16'sh1000,
			16'sh1000, 16'sh7fff, 16'sh8000, 16'sd1}), 1,
			frame_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			16'sd0, 16'sh7fff, 16'sh8000, 16'sd1})});
		directed.push_back('{req_t'({16'sd0, 16'sh1000, 16'sd0, 16'sh1000, 16'sh1000,
			16'sh1000, 16'sd0, 16'sd0, 16'sd0}), 1,
			frame_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			16'sh1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0})});
		directed.push_back('{req_t'({16'sd0, 16'sd0, 16'sh1000, 16'sh1000, 16'sh1000,
			16'sh1000, 16'sd0, 16'sd0, 16'sd0}), 1,
			frame_t'({16'sh1000, 16'sd0, 16'sd0, 16'sd0, 16'sh1000, 16'sd0, 16'sd0,
			16'sd0, 16'sh1000, 16'sd0, 16'sd0, 16'sd0})});
		directed.push_back('{req_t'({16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sd0, 16'sd0, 16'sd0}), 1,
			frame_t'({16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0,
			16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0})});
		directed.push_back('{req_t'({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}), 0, z});
		directed.push_back('{req_t'({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}), 0, z});
		directed.push_back('{req_t'({16'sh8000, 16'sh7fff, 16'sd1, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0}), 0, z});
		directed.push_back('{req_t'({16'sd1, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'shffff, 16'sd0, 16'sd0}), 0, z});
		directed.push_back('{req_t'({16'sd1, 16'sd1, 16'sd1, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sd0, 16'sd0, 16'sd0}), 0, z});
		directed.push_back('{req_t'({16'shffff, 16'sh8000, 16'sd0, 16'sh1000,
			16'shf000, 16'sh0800, 16'sd0, 16'sd0, 16'sd0}), 0, z});
		directed.push_back('{req_t'({16'sd3, 16'sd4, 16'sd0, 16'sh5555, 16'shaaaa,
			16'sh1234, 16'sd0, 16'sd0, 16'sd0}), 0, z});

		in_valid = 0;
		{dir_x, dir_y, dir_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z} = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i]) begin
			send(directed[i].r);
			if (directed[i].has_exp && frames_due[$] != directed[i].e) begin
				$display("directed row %0d: typed value differs from predictor", i);
				errors++;
			end
		end
		for (int n = 0; n < N_RAND; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RAND; k++, n++) send(rand_req());
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			case ((cycles / 200) % 3)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ((cycles % 7) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		frame_t got, want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			got = {right_x, right_y, right_z, up_x, up_y, up_z,
				fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z};
			if (frames_due.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				want = frames_due.pop_front();
				if (got.rx != want.rx) report("right_x", got.rx, want.rx);
				if (got.ry != want.ry) report("right_y", got.ry, want.ry);
				if (got.rz != want.rz) report("right_z", got.rz, want.rz);
				if (got.ux != want.ux) report("up_x", got.ux, want.ux);
				if (got.uy != want.uy) report("up_y", got.uy, want.uy);
				if (got.uz != want.uz) report("up_z", got.uz, want.uz);
				if (got.fx != want.fx) report("fwd_x", got.fx, want.fx);
				if (got.fy != want.fy) report("fwd_y", got.fy, want.fy);
				if (got.fz != want.fz) report("fwd_z", got.fz, want.fz);
				if (got.tx != want.tx) report("trans_x", got.tx, want.tx);
				if (got.ty != want.ty) report("trans_y", got.ty, want.ty);
				if (got.tz != want.tz) report("trans_z", got.tz, want.tz);
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		stim_done = 0;
		fork
			begin
				wait (stim_done && frames_due.size() == 0);
				repeat (2 * LATENCY) @(posedge clk);
			end
			begin
				wait (cycles >= LIMIT);
				$display("timeout");
				errors++;
			end
		join_any
		if (errors == 0)
			$display("basis_matrix_from_direction regression: pass");
		else
			$display("basis_matrix_from_direction regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/bmfd_pkg.sv
src/bmfd_pipe_reg.sv
src/bmfd_isqrt.sv
src/bmfd_div.sv
src/basis_matrix_from_direction.sv
tb/sv/tb.sv
